[hw/rtl/tcdc_pkg.sv]
// shared types and constants of the triangle corner direction classifier
package tcdc_pkg;

    // width in which coordinates are interpreted
    localparam int COORD_WIDTH = 32;

    // width of each coordinate field on the item ports
    localparam int FIELD_W = COORD_WIDTH;

    // clock edges from the accepting edge to the edge that takes the result
    localparam int LATENCY = 6;

    typedef enum logic [1:0] {
        DIR_IN   = 2'd0,
        DIR_EDGE = 2'd1,
        DIR_OUT  = 2'd2
    } t_dir;

    typedef struct packed {
        logic signed [FIELD_W-1:0] corner0_x;
        logic signed [FIELD_W-1:0] corner0_y;
        logic signed [FIELD_W-1:0] corner1_x;
        logic signed [FIELD_W-1:0] corner1_y;
        logic signed [FIELD_W-1:0] corner2_x;
        logic signed [FIELD_W-1:0] corner2_y;
        logic signed [FIELD_W-1:0] vel0_x;
        logic signed [FIELD_W-1:0] vel0_y;
        logic signed [FIELD_W-1:0] vel1_x;
        logic signed [FIELD_W-1:0] vel1_y;
        logic signed [FIELD_W-1:0] vel2_x;
        logic signed [FIELD_W-1:0] vel2_y;
    } t_in_item;

    typedef struct packed {
        t_dir dir_first;
        t_dir dir_second;
        t_dir dir_third;
        logic degenerate;
    } t_out_item;

    // per corner control: sense of the two tests and the degenerate case
    typedef struct packed {
        logic inv_x;
        logic inv_y;
        logic degen;
    } t_corner_ctl;

endpackage

[hw/rtl/tcdc_mul.sv]
// two stage signed multiplier built from four half width partial products
module tcdc_mul #(
    parameter int W = tcdc_pkg::COORD_WIDTH + 2
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    localparam int L = (W + 1) / 2;
    localparam int H = W - L;

    logic signed [H-1:0]     a_h;
    logic signed [H-1:0]     b_h;
    logic signed [L:0]       a_l;
    logic signed [L:0]       b_l;

    logic signed [2*H-1:0]   r_hh;
    logic signed [H+L:0]     r_hl;
    logic signed [H+L:0]     r_lh;
    logic        [2*L-1:0]   r_ll;
    logic signed [2*W-1:0]   r_p;
    logic signed [2*W-1:0]   n_p;

    assign a_h = i_a[W-1:L];
    assign b_h = i_b[W-1:L];
    assign a_l = $signed({1'b0, i_a[L-1:0]});
    assign b_l = $signed({1'b0, i_b[L-1:0]});

    always_ff @(posedge i_clk) begin
        r_hh <= a_h * b_h;
        r_hl <= a_h * b_l;
        r_lh <= a_l * b_h;
        r_ll <= i_a[L-1:0] * i_b[L-1:0];
    end

    always_comb begin
        n_p = ((2*W)'(r_hh) <<< (2*L))
            + (((2*W)'(r_hl) + (2*W)'(r_lh)) <<< L)
            + $signed({{(2*W-2*L){1'b0}}, r_ll});
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

[hw/rtl/tcdc_corner.sv]
// direction decision for one corner from its two tight constraints
module tcdc_corner #(
    parameter int SW = 2 * (tcdc_pkg::COORD_WIDTH + 2) + 2
) (
    input  logic signed [SW-1:0]  i_x,
    input  logic signed [SW-1:0]  i_y,
    input  tcdc_pkg::t_corner_ctl i_ctl,
    output tcdc_pkg::t_dir        o_dir
);

    logic x_zero;
    logic y_zero;
    logic x_ok;
    logic y_ok;

    always_comb begin
        x_zero = (i_x == '0);
        y_zero = (i_y == '0);
        // a test passes when the quantity, with its sense applied, is not negative
        x_ok = i_ctl.inv_x ? (i_x[SW-1] | x_zero) : ~i_x[SW-1];
        y_ok = i_ctl.inv_y ? (i_y[SW-1] | y_zero) : ~i_y[SW-1];
        if (i_ctl.degen || !(x_ok && y_ok)) begin
            o_dir = tcdc_pkg::DIR_OUT;
        end else if (x_zero || y_zero) begin
            o_dir = tcdc_pkg::DIR_EDGE;
        end else begin
            o_dir = tcdc_pkg::DIR_IN;
        end
    end

endmodule

[hw/rtl/triangle_corner_direction_classifier_core.sv]
// top level of the triangle corner direction classifier
//
// usage
//   - one triangle item (three corners, one velocity per corner, signed q16.16)
//     is taken on i_item at each rising edge with start high and busy low
//   - busy is always low: the block is a fixed pipeline and takes an item
//     in every cycle, so one triangle per clock is sustained
//   - the result item (three corner directions and a degenerate flag) shows
//     on o_result with o_valid high for exactly one cycle
//   - o_valid rises as the result register takes the result; results leave
//     in the order the items came in
//   - the depth is set by the input register, the difference stage, the two
//     stage split multipliers, the cross product stage and the result register
//   - the receiver cannot stall, so there is no back pressure anywhere
//   - a synchronous reset (i_rst_n low) drops every item in flight;
//     no result follows an item whose path through the pipe saw reset
//   - coordinates are read in COORD_WIDTH bits, sign extended; bits of a
//     field above COORD_WIDTH are ignored
//   - a zero area triangle sets degenerate and reports all corners outwards
module triangle_corner_direction_classifier_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tcdc_pkg::t_in_item  i_item,
    output logic                o_valid,
    output tcdc_pkg::t_out_item o_result
);

    localparam int COORD_WIDTH = tcdc_pkg::COORD_WIDTH;
    localparam int EXT_W = (COORD_WIDTH > tcdc_pkg::FIELD_W) ? COORD_WIDTH : tcdc_pkg::FIELD_W;
    // operand width: corner minus velocity relative to corner0 needs two extra bits
    localparam int OW    = COORD_WIDTH + 2;
    localparam int PW    = 2 * OW;
    // sum width: u + v - det stays inside two more bits
    localparam int SW    = PW + 2;
    localparam int NSTG  = 5;

    // interpret a field as a COORD_WIDTH bit signed coordinate
    function automatic logic signed [OW-1:0] to_coord(input logic [tcdc_pkg::FIELD_W-1:0] f);
        logic [EXT_W-1:0]              ext;
        logic signed [COORD_WIDTH-1:0] c;
        ext = EXT_W'(f);
        c   = $signed(ext[COORD_WIDTH-1:0]);
        return OW'(c);
    endfunction

    // valid pipe: input reg, differences, mul stage 1, mul stage 2, cross products
    logic [NSTG-1:0] r_vld;
    logic            r_out_vld;

    // input register
    tcdc_pkg::t_in_item r_in;

    // difference stage
    logic signed [OW-1:0] n_e1x, n_e1y, n_e2x, n_e2y;
    logic signed [OW-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [OW-1:0] n_wx [3];
    logic signed [OW-1:0] n_wy [3];
    logic signed [OW-1:0] r_wx [3];
    logic signed [OW-1:0] r_wy [3];

    // products
    logic signed [PW-1:0] p_det_a, p_det_b;
    logic signed [PW-1:0] p_ua [3];
    logic signed [PW-1:0] p_ub [3];
    logic signed [PW-1:0] p_va [3];
    logic signed [PW-1:0] p_vb [3];

    // cross product stage: scaled reference coordinates and determinant
    logic signed [SW-1:0] r_u [3];
    logic signed [SW-1:0] r_v [3];
    logic signed [SW-1:0] r_det;

    // final stage: u + v - det only for the second and third corners
    logic signed [SW-1:0]  n_t [1:2];
    logic                  flip;
    logic                  degen;
    tcdc_pkg::t_dir        dir [3];
    tcdc_pkg::t_out_item   n_result;
    tcdc_pkg::t_out_item   r_result;
    tcdc_pkg::t_corner_ctl ctl [3];

    // never holds items off
    assign busy = 1'b0;

    // control pipe, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[NSTG-2:0], start & ~busy};
            r_out_vld <= r_vld[NSTG-1];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    // edges from corner0 and the points corner minus velocity, relative to corner0
    always_comb begin
        n_e1x = to_coord(r_in.corner1_x) - to_coord(r_in.corner0_x);
        n_e1y = to_coord(r_in.corner1_y) - to_coord(r_in.corner0_y);
        n_e2x = to_coord(r_in.corner2_x) - to_coord(r_in.corner0_x);
        n_e2y = to_coord(r_in.corner2_y) - to_coord(r_in.corner0_y);
        n_wx[0] = -to_coord(r_in.vel0_x);
        n_wy[0] = -to_coord(r_in.vel0_y);
        n_wx[1] = n_e1x - to_coord(r_in.vel1_x);
        n_wy[1] = n_e1y - to_coord(r_in.vel1_y);
        n_wx[2] = n_e2x - to_coord(r_in.vel2_x);
        n_wy[2] = n_e2y - to_coord(r_in.vel2_y);
    end

    always_ff @(posedge i_clk) begin
        r_e1x <= n_e1x;
        r_e1y <= n_e1y;
        r_e2x <= n_e2x;
        r_e2y <= n_e2y;
        r_wx  <= n_wx;
        r_wy  <= n_wy;
    end

    // determinant products
    tcdc_mul #(.W(OW)) u_mul_det_a (.i_clk(i_clk), .i_a(r_e1x), .i_b(r_e2y), .o_p(p_det_a));
    tcdc_mul #(.W(OW)) u_mul_det_b (.i_clk(i_clk), .i_a(r_e2x), .i_b(r_e1y), .o_p(p_det_b));

    // four products per corner: u = e2y*wx - e2x*wy, v = e1x*wy - e1y*wx
    for (genvar j = 0; j < 3; j++) begin : g_corner_mul
        tcdc_mul #(.W(OW)) u_mul_ua (.i_clk(i_clk), .i_a(r_e2y), .i_b(r_wx[j]), .o_p(p_ua[j]));
        tcdc_mul #(.W(OW)) u_mul_ub (.i_clk(i_clk), .i_a(r_e2x), .i_b(r_wy[j]), .o_p(p_ub[j]));
        tcdc_mul #(.W(OW)) u_mul_va (.i_clk(i_clk), .i_a(r_e1x), .i_b(r_wy[j]), .o_p(p_va[j]));
        tcdc_mul #(.W(OW)) u_mul_vb (.i_clk(i_clk), .i_a(r_e1y), .i_b(r_wx[j]), .o_p(p_vb[j]));
    end

    // cross products
    always_ff @(posedge i_clk) begin
        r_det <= SW'(p_det_a) - SW'(p_det_b);
        for (int j = 0; j < 3; j++) begin
            r_u[j] <= SW'(p_ua[j]) - SW'(p_ub[j]);
            r_v[j] <= SW'(p_va[j]) - SW'(p_vb[j]);
        end
    end

    // a negative determinant flips the sense of every test
    assign flip  = r_det[SW-1];
    assign degen = (r_det == '0);

    always_comb begin
        for (int j = 1; j < 3; j++) begin
            n_t[j] = r_u[j] + r_v[j] - r_det;
        end
        // first corner: u >= 0 and v >= 0
        ctl[0] = '{inv_x: flip, inv_y: flip, degen: degen};
        // second corner: v >= 0 and u + v <= det
        ctl[1] = '{inv_x: flip, inv_y: ~flip, degen: degen};
        // third corner: u >= 0 and u + v <= det
        ctl[2] = '{inv_x: flip, inv_y: ~flip, degen: degen};
    end

    tcdc_corner #(.SW(SW)) u_corner_first (
        .i_x(r_u[0]), .i_y(r_v[0]), .i_ctl(ctl[0]), .o_dir(dir[0])
    );
    tcdc_corner #(.SW(SW)) u_corner_second (
        .i_x(r_v[1]), .i_y(n_t[1]), .i_ctl(ctl[1]), .o_dir(dir[1])
    );
    tcdc_corner #(.SW(SW)) u_corner_third (
        .i_x(r_u[2]), .i_y(n_t[2]), .i_ctl(ctl[2]), .o_dir(dir[2])
    );

    always_comb begin
        n_result.dir_first  = dir[0];
        n_result.dir_second = dir[1];
        n_result.dir_third  = dir[2];
        n_result.degenerate = degen;
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_result;

endmodule

[hw/rtl/tcdc_checker.sv]
// port level checks of the classifier and their binding to the top level
module tcdc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input tcdc_pkg::t_in_item  i_item,
    input logic                o_valid,
    input tcdc_pkg::t_out_item o_result
);

    // reset empties the pipe
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // every accepted item yields a result after the fixed latency
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(tcdc_pkg::LATENCY) o_valid)
        else $error("accepted item produced no result");

    // no result without an item accepted at the matching edge
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, tcdc_pkg::LATENCY))
        else $error("result without accepted item");

    // a degenerate triangle reports every corner outwards
    a_degenerate_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.degenerate) |->
            (o_result.dir_first == tcdc_pkg::DIR_OUT) &&
            (o_result.dir_second == tcdc_pkg::DIR_OUT) &&
            (o_result.dir_third == tcdc_pkg::DIR_OUT))
        else $error("degenerate result with a corner not outwards");

endmodule

bind triangle_corner_direction_classifier_core tcdc_checker u_tcdc_checker (.*);
